@@ design/signed_int_to_padded_decimal_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to padded decimal block.
// Each module that uses them has signals named clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_PADDED_DECIMAL_DEFINES_SVH
`define SIGNED_INT_TO_PADDED_DECIMAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sipd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sipd assertion failed");

`endif

@@ design/sipd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_pkg
// Types and constants shared by the padded decimal converter.
// ----------------------------------------------------------------------------
package sipd_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int PAD_W      = 6;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS     = 10;
  localparam int CNT_W      = 4;
  localparam int POS_W      = 6;
  localparam int OUT_LIMIT  = 32;
  localparam int PAD_MAX    = OUT_LIMIT - 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef logic [DIGIT_W-1:0] digit_t;

  // One converted value: digits least significant first, digit count, sign.
  typedef struct packed {
    digit_t [DIGITS-1:0] digits;
    logic [CNT_W-1:0]    count;
    logic                neg;
  } conv_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIG,
    F_PUSH
  } front_state_t;

endpackage

@@ design/sipd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd channel interfaces
// Valid/ready channels for input values, output characters and pad width.
// ----------------------------------------------------------------------------
interface sipd_in_if;
  import sipd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sipd_out_if;
  import sipd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;
  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

interface sipd_cfg_if;
  import sipd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PAD_W-1:0] pad_width;
  modport source (output valid, output pad_width, input ready);
  modport sink (input valid, input pad_width, output ready);
endinterface

@@ design/signed_int_to_padded_decimal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal
// Signed 32-bit integer to right-justified decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one signed value per word. out_bus returns its text one
//   character per word, most significant first, with last set on the final
//   character. Negative values get a leading minus sign; leading spaces pad
//   the text to the pad width, which is clamped to OUT_LIMIT - 1 (0 = none).
//   cfg_bus writes the pad width; write it only while no value is in flight.
//   The front splits a value into digits, each by a reciprocal multiply
//   and then the remainder, and then offers the result to the queue. The
//   back loads a value from the queue, then emits one character per cycle
//   while the receiver is ready; it loads the next value only after it has
//   registered the last character of the current one. The next value is
//   converted while the current one is still being emitted.
//   Reset clears the pad width to zero and empties the queue. A stalled
//   receiver holds the current character; the back, then the queue and then
//   the front fill up and in_bus.ready drops.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal (
  input  logic        clk,
  input  logic        rst_n,
  sipd_in_if.sink     in_bus,
  sipd_cfg_if.sink    cfg_bus,
  sipd_out_if.source  out_bus
);
  import sipd_pkg::*;

  logic  push_valid, push_ready;
  conv_t push_data;
  logic  pop_valid, pop_ready;
  conv_t pop_data;

  sipd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sipd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sipd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_bus    (cfg_bus),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_bus    (out_bus)
  );

endmodule

@@ design/sipd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_front
// Accepts a value, takes its magnitude and splits it into decimal digits.
// ----------------------------------------------------------------------------
`include "signed_int_to_padded_decimal_defines.svh"
module sipd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  sipd_in_if.sink                 in_bus,
  output logic                    push_valid,
  input  logic                    push_ready,
  output sipd_pkg::conv_t         push_data
);
  import sipd_pkg::*;

  front_state_t            state_r, state_nxt;
  logic [VALUE_W-1:0]      mag_r, mag_nxt;
  logic [2*VALUE_W-1:0]    prod_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  digit_t [DIGITS-1:0]     digits_r;
  logic                    neg_r;
  logic [QUOT_W-1:0]       quot;
  logic [VALUE_W-1:0]      quot_ext;
  logic [VALUE_W-1:0]      quot_x10;
  logic [VALUE_W-1:0]      rem;
  logic                    accept;

  assign accept   = in_bus.valid && in_bus.ready;
  assign quot     = prod_r[2*VALUE_W-1:RECIP_SHIFT];
  assign quot_ext = {{(VALUE_W-QUOT_W){1'b0}}, quot};
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem      = mag_r - quot_x10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    prod_r <= mag_r * RECIP_10;
    if (accept) begin
      neg_r <= in_bus.value[VALUE_W-1];
    end
    if (state_r == F_DIG) begin
      digits_r[cnt_r] <= rem[DIGIT_W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mag_nxt      = mag_r;
    in_bus.ready = 1'b0;
    push_valid   = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          // Negating the most negative value wraps to its exact magnitude.
          mag_nxt   = in_bus.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_bus.value))
                                              : VALUE_W'(in_bus.value);
          cnt_nxt   = '0;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_DIG;
      end
      F_DIG: begin
        mag_nxt = quot_ext;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (quot == '0 || cnt_r == CNT_W'(DIGITS - 1)) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_MUL;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_data.digits = digits_r;
  assign push_data.count  = cnt_r;
  assign push_data.neg    = neg_r;

  `SIPD_ASSERT_NOW(a_front_digit_room, state_r == F_DIG, cnt_r < CNT_W'(DIGITS))
  `SIPD_ASSERT_NOW(a_front_count_ok, state_r == F_PUSH,
                   cnt_r != '0 && cnt_r <= CNT_W'(DIGITS))

endmodule

@@ design/sipd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_fifo
// Short queue of converted values between the front and the back.
// ----------------------------------------------------------------------------
`include "signed_int_to_padded_decimal_defines.svh"
module sipd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sipd_pkg::conv_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sipd_pkg::conv_t pop_data
);
  import sipd_pkg::*;

  conv_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign push_ready = count_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SIPD_ASSERT_NOW(a_fifo_bound, 1'b1, count_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `SIPD_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, count_r != '0)

endmodule

@@ design/sipd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_back
// Holds the pad width and emits the padded text one character per word.
// ----------------------------------------------------------------------------
`include "signed_int_to_padded_decimal_defines.svh"
module sipd_back (
  input  logic            clk,
  input  logic            rst_n,
  sipd_cfg_if.sink        cfg_bus,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sipd_pkg::conv_t pop_data,
  sipd_out_if.source      out_bus
);
  import sipd_pkg::*;

  logic [PAD_W-1:0]  pad_width_r;
  logic              busy_r;
  conv_t             ent_r;
  logic [POS_W-1:0]  pos_r, pad_r, total_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r, char_nxt;
  logic              out_last_r, last_nxt;
  logic              advance, load;
  logic [POS_W-1:0]  text_len, target, pad_nxt, didx;

  assign cfg_bus.ready = 1'b1;
  assign pop_ready     = !busy_r;
  assign load          = pop_valid && !busy_r;
  assign advance       = busy_r && (!out_valid_r || out_bus.ready);

  // Field width for the value being loaded, clamped to PAD_MAX (OUT_LIMIT - 1).
  assign text_len = POS_W'(pop_data.count) + POS_W'(pop_data.neg);
  assign target   = (POS_W'(pad_width_r) > POS_W'(PAD_MAX)) ? POS_W'(PAD_MAX)
                                                           : POS_W'(pad_width_r);
  assign pad_nxt  = (target > text_len) ? (target - text_len) : '0;

  // Digits are stored least significant first, so count back from the end.
  assign didx = total_r - POS_W'(1) - pos_r;

  always_comb begin
    last_nxt = (pos_r == total_r - POS_W'(1));
    if (pos_r < pad_r) begin
      char_nxt = CH_SPACE;
    end else if (ent_r.neg && pos_r == pad_r) begin
      char_nxt = CH_MINUS;
    end else begin
      char_nxt = CH_ZERO + CHAR_W'(ent_r.digits[didx[CNT_W-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_width_r <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        pad_width_r <= cfg_bus.pad_width;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (advance && last_nxt) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r   <= pop_data;
      pos_r   <= '0;
      pad_r   <= pad_nxt;
      total_r <= pad_nxt + text_len;
    end else if (advance) begin
      pos_r <= pos_r + POS_W'(1);
    end
    if (advance) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.out_char = out_char_r;
  assign out_bus.last     = out_last_r;

  `SIPD_ASSERT_NOW(a_back_pos_range, busy_r, pos_r < total_r)
  `SIPD_ASSERT_NOW(a_back_digit_range,
                   busy_r && pos_r > pad_r,
                   didx < POS_W'(ent_r.count))
  `SIPD_ASSERT_NEXT(a_back_last_frees, advance && last_nxt, !busy_r)

endmodule

@@ tb/signed_int_to_padded_decimal_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_tb
// The testbench sends signed 32-bit values under a range of pad widths,
// from zero to the 6-bit maximum. A local predictor turns each accepted
// value into its right-justified decimal characters. Every output word is
// checked in order against those characters and their last flags. Both
// sides throttle at random. One phase also holds the output off long enough
// to back the block up.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_tb;
  import sipd_pkg::*;

  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 26;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;

  sipd_in_if  in_ch ();
  sipd_out_if out_ch ();
  sipd_cfg_if cfg_ch ();

  signed_int_to_padded_decimal dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .cfg_bus (cfg_ch),
    .out_bus (out_ch)
  );

  logic signed [VALUE_W-1:0] pending_values [$];
  text_char_t                expected_text [$];
  logic [PAD_W-1:0]          pad_setting;
  logic                      hold_rx;
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;
  int unsigned               fail_count;
  int unsigned               values_sent;
  int unsigned               chars_checked;
  int unsigned               widths_used;
  logic [VALUE_W-1:0]        edge_values [20];
  logic [PAD_W-1:0]          phase_pad [PHASES];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Expand one value into the characters the block should emit for it.
  function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    digit_t             digs [DIGITS];
    logic               neg;
    int                 n;
    int                 text_len;
    int                 target;
    int                 pad;
    int                 total;
    int                 k;
    neg = v[VALUE_W-1];
    mag = neg ? (32'd0 - $unsigned(v)) : $unsigned(v);
    n = 0;
    do begin
      digs[n] = digit_t'(mag % 32'd10);
      n++;
      mag = mag / 32'd10;
    end while (mag != 0 && n < DIGITS);
    text_len = n + (neg ? 1 : 0);
    target = (int'(pad_setting) > PAD_MAX) ? PAD_MAX : int'(pad_setting);
    pad = (target > text_len) ? target - text_len : 0;
    total = pad + text_len;
    k = 0;
    repeat (pad) begin
      k++;
      expected_text.push_back('{ch: CH_SPACE, last: (k == total)});
    end
    if (neg) begin
      k++;
      expected_text.push_back('{ch: CH_MINUS, last: (k == total)});
    end
    for (int i = n - 1; i >= 0; i--) begin
      k++;
      expected_text.push_back('{ch: CH_ZERO + CHAR_W'(digs[i]), last: (k == total)});
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] pw;
    case ($urandom_range(5))
      0, 1: r = $urandom();
      2: r = $urandom_range(999);
      3: begin
        pw = 1;
        repeat ($urandom_range(9)) pw = pw * 10;
        r = pw + $urandom_range(2) - 1;
      end
      4: begin
        case ($urandom_range(4))
          0: r = 32'h0000_0000;
          1: r = 32'h7FFF_FFFF;
          2: r = 32'h8000_0000;
          3: r = 32'h8000_0001;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      default: r = $urandom_range(99999999);
    endcase
    // Any value but 32'h8000_0000 gets either sign at random.
    if ($urandom_range(1) == 1 && r != 32'h8000_0000) r = -r;
    return $signed(r);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_ch.valid || expected_text.size() != 0);
  endtask

  task automatic write_pad(input logic [PAD_W-1:0] w);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.pad_width <= w;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    pad_setting = w;
    widths_used++;
    @(negedge clk);
  endtask

  // Sender: holds a word until it is taken, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_text(in_ch.value);
        values_sent++;
      end
      if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_values.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each taken word against the oldest expected character.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected word char=%h last=%b", $realtime,
                     out_ch.out_char, out_ch.last);
        end else begin
          want = expected_text.pop_front();
          if (out_ch.out_char !== want.ch || out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b",
                       $realtime, want.ch, out_ch.out_char, want.last, out_ch.last);
          end
        end
      end
      out_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.pad_width = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    hold_rx          = 1'b0;
    pad_setting      = '0;
    send_idle_pct    = 29;
    recv_idle_pct    = 86;
    fail_count       = 0;
    values_sent      = 0;
    chars_checked    = 0;
    widths_used      = 0;
    edge_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
                    32'h0000_000A, 32'hFFFF_FFF6, 32'h0000_0063, 32'h0000_0064,
                    32'hFFFF_FF9C, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'h3B9A_CA00, 32'h3B9A_C9FF, 32'hC465_3601, 32'h4996_02D2,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_3039, 32'hFFFF_FFFB};
    phase_pad = '{6'd63, 6'd33, 6'd1, 6'd5, 6'd16, 6'd11, 6'd32, 6'd0, 6'd20};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No padding: every text comes out at its natural length.
    write_pad(6'd0);
    foreach (edge_values[i]) pending_values.push_back($signed(edge_values[i]));
    wait_drained();

    // Widest field the block allows.
    write_pad(6'd31);
    pending_values.push_back(32'sh0000_0000);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'shFFFF_FFFF);
    pending_values.push_back(32'sh5555_5555);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 29;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_pad(phase_pad[p]);
      if (p == 4) begin
        // Stall the output while words keep coming so the input backs up.
        hold_rx <= 1'b1;
        repeat (PHASE_ITEMS) pending_values.push_back(random_value());
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end else if (p == 6) begin
        // Let the block drain completely halfway through.
        repeat (PHASE_ITEMS / 2) pending_values.push_back(random_value());
        wait_drained();
        repeat (PHASE_ITEMS - PHASE_ITEMS / 2) pending_values.push_back(random_value());
      end else begin
        repeat (PHASE_ITEMS) pending_values.push_back(random_value());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) fail_count++;

    $display("Converted %0d values into %0d checked characters across %0d pad widths.",
             values_sent, chars_checked, widths_used);
    $display("Mismatches and stray words seen: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sipd_pkg.sv
design/sipd_if.sv
design/sipd_front.sv
design/sipd_fifo.sv
design/sipd_back.sv
design/signed_int_to_padded_decimal.sv
tb/signed_int_to_padded_decimal_tb.sv
